### design/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes for the ordered list engine: request and response
// words, operation and status codes.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int POS_W = 5;
  localparam int FND_W = 4;
  localparam int LEN_W = 5;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_REMOVE_AT  = 2'd2,
    OP_FIND       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [FND_W-1:0] fnd_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
    pos_t                    position;
  } req_t;

  typedef struct packed {
    status_e status;
    fnd_t    found_at;
    len_t    length;
  } rsp_t;

endpackage

### design/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Ordered list of up to CAPACITY signed 32-bit values held in one
// synchronous memory, with push front, push back, remove at and find.
//
// Request words enter on req (req_valid/req_ready), one response word per
// request leaves on rsp (rsp_valid/rsp_ready). One request is worked on at a
// time; req_ready is high whenever the engine is idle, also while a response
// still waits in the output register. With start index p, push back and any
// rejected request go straight to the response; push front shifts every entry
// up by one from the top and then writes the new value at index 0; remove at
// shifts the entries above p down by one; find searches upward from p and
// stops at the first match. req_ready rises together with rsp_valid, as the
// response loads. Shifts and searches use the memory's single read port and
// move one entry per cycle, pipelined across its registered read. Reset empties
// the list; memory contents are not cleared and are only read below the entry
// count. A stalled receiver holds the response; the engine then takes one
// more request and finishes it into its result registers, and waits there
// until the output register frees.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit
  import ole_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_PUT, S_DONE} state_t;

  state_t             state;
  op_e                op_r;
  logic [VAL_W-1:0]   val_r;
  logic [AW-1:0]      idx;
  logic [CNT_W-1:0]   left;
  logic               pend;
  logic [AW-1:0]      pend_idx;
  logic [CNT_W-1:0]   cnt;
  status_e            st_r;
  fnd_t               fnd_r;

  logic [VAL_W-1:0]   mem [CAPACITY];
  logic [VAL_W-1:0]   rdata;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VAL_W-1:0]   wdata;
  logic               re;
  logic               full;
  logic               pos_ok;
  logic [CNT_W-1:0]   pos_c;
  logic               matched;

  assign req_ready = (state == S_IDLE);
  assign full      = (cnt == CNT_W'(CAPACITY));
  assign pos_ok    = CMP_W'(req.position) < CMP_W'(cnt);
  assign pos_c     = CNT_W'(req.position);
  assign re        = (state == S_WALK) && (left != '0);
  assign matched   = (state == S_WALK) && pend && (op_r == OP_FIND) && (rdata == val_r);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req.op == OP_PUSH_BACK && !full) begin
          we    = 1'b1;
          waddr = AW'(cnt);
          wdata = req.value;
        end
      end
      S_WALK: begin
        if (pend && op_r != OP_FIND) begin
          we    = 1'b1;
          waddr = (op_r == OP_PUSH_FRONT) ? pend_idx + 1'b1 : pend_idx - 1'b1;
        end
      end
      S_PUT: begin
        we    = 1'b1;
        wdata = val_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      left      <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r  <= req.op;
            val_r <= req.value;
            fnd_r <= '0;
            st_r  <= ST_OK;
            pend  <= 1'b0;
            state <= S_DONE;
            unique case (req.op)
              OP_PUSH_FRONT: begin
                if (full) begin
                  st_r <= ST_FULL;
                end else begin
                  left  <= cnt;
                  idx   <= AW'(cnt - 1'b1);
                  state <= S_WALK;
                end
              end
              OP_PUSH_BACK: begin
                if (full) begin
                  st_r <= ST_FULL;
                end else begin
                  cnt <= cnt + 1'b1;
                end
              end
              OP_REMOVE_AT: begin
                if (!pos_ok) begin
                  st_r <= ST_MISS;
                end else begin
                  left  <= cnt - pos_c - 1'b1;
                  idx   <= AW'(pos_c + 1'b1);
                  state <= S_WALK;
                end
              end
              OP_FIND: begin
                if (!pos_ok) begin
                  st_r <= ST_MISS;
                end else begin
                  left  <= cnt - pos_c;
                  idx   <= AW'(pos_c);
                  state <= S_WALK;
                end
              end
            endcase
          end
        end
        S_WALK: begin
          if (matched) begin
            fnd_r <= fnd_t'(pend_idx);
            pend  <= 1'b0;
            left  <= '0;
            state <= S_DONE;
          end else if (left != '0) begin
            idx      <= (op_r == OP_PUSH_FRONT) ? idx - 1'b1 : idx + 1'b1;
            left     <= left - 1'b1;
            pend     <= 1'b1;
            pend_idx <= idx;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            unique case (op_r)
              OP_PUSH_FRONT: state <= S_PUT;
              OP_REMOVE_AT: begin
                cnt   <= cnt - 1'b1;
                state <= S_DONE;
              end
              OP_FIND: begin
                st_r  <= ST_MISS;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_PUT: begin
          cnt   <= cnt + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            rsp.status   <= st_r;
            rsp.found_at <= fnd_r;
            rsp.length   <= len_t'(cnt);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count past capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.length == len_t'(CAPACITY))
    else $error("full response with list not at capacity");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.found_at == '0)
    else $error("found_at set on a failed request");

  a_find_nowrite: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && op_r == OP_FIND |-> !we)
    else $error("memory write during find");

endmodule

### sim/ordered_list_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit_tb
// Self-checking bench for the ordered list engine. A scoreboard keeps its own
// copy of the list, computes the response word for every accepted request and
// compares each returned word field by field. Directed requests cover the
// empty and full list and the value and index extremes. Random requests
// follow, in filling and draining phases with random idle cycles on both
// sides, plus one long receiver stall that backs the engine up.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit_tb;
  import ole_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_WORDS = 600;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 40;

  class list_scoreboard #(int DEPTH = 16);
    logic [VAL_W-1:0] slots [DEPTH];
    int unsigned      fill;
    rsp_t             expected_q [$];
    int unsigned      errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_request(req_t w);
      rsp_t        r;
      int unsigned i;
      bit          hit;
      r.status   = ST_OK;
      r.found_at = '0;
      hit        = 1'b0;
      case (w.op)
        OP_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > 0; i--) slots[i] = slots[i-1];
            slots[0] = w.value;
            fill++;
          end
        end
        OP_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slots[fill] = w.value;
            fill++;
          end
        end
        OP_REMOVE_AT: begin
          if (w.position >= fill) begin
            r.status = ST_MISS;
          end else begin
            for (i = w.position; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        default: begin
          r.status = ST_MISS;
          for (i = w.position; i < fill && !hit; i++) begin
            if (slots[i] === w.value) begin
              hit        = 1'b1;
              r.status   = ST_OK;
              r.found_at = fnd_t'(i);
            end
          end
        end
      endcase
      r.length = len_t'(fill);
      expected_q.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $error("response word with none outstanding: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.found_at !== want.found_at) begin
        $error("found_at: expected %0d, got %0d", want.found_at, got.found_at);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  list_scoreboard #(CAPACITY) sb;
  logic signed [VAL_W-1:0]    value_pool [6];
  int unsigned                sent_count;
  int unsigned                recv_count;

  ordered_list_engine_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) begin
        sb.check_response(rsp);
        recv_count++;
      end
    end
  end

  task automatic send_word(input op_e op, input logic signed [VAL_W-1:0] v,
                           input pos_t p);
    req_t        w;
    int unsigned gap;
    w.op       = op;
    w.value    = v;
    w.position = p;
    gap = ((sent_count / 50) % 3 == 2) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent_count++;
  endtask

  function automatic req_t random_word(input bit filling);
    req_t        w;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) w.op = OP_FIND;
    else if (roll < (filling ? 85 : 40))
      w.op = ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    else w.op = OP_REMOVE_AT;
    w.value = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 5)] : $urandom;
    w.position = ($urandom_range(0, 2) == 0) ? pos_t'($urandom_range(0, 16))
                                             : pos_t'($urandom_range(0, 4));
    return w;
  endfunction

  // receiver: random stalls, stretches without stalls, one long hold
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    rsp_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = ((recv_count / 60) % 3 == 1) ? 0 : $urandom_range(0, 6);
      if (!held && recv_count >= 150) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
    end
  end

  initial begin
    #2000000;
    $display("ordered_list_engine_unit_tb: FAIL");
    $finish;
  end

  initial begin
    req_t w;
    sb         = new();
    sent_count = 0;
    recv_count = 0;
    value_pool[0] = 32'sh0000_0000;
    value_pool[1] = -32'sd1;
    value_pool[2] = 32'sh8000_0000;
    value_pool[3] = 32'sh7fff_ffff;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty list, extremes
    send_word(OP_REMOVE_AT, 32'sd0, 5'd0);
    send_word(OP_FIND, 32'sd0, 5'd0);
    send_word(OP_PUSH_BACK, 32'sh8000_0000, 5'd0);
    send_word(OP_PUSH_FRONT, 32'sh7fff_ffff, 5'd31);
    send_word(OP_PUSH_BACK, -32'sd1, 5'd0);
    send_word(OP_FIND, -32'sd1, 5'd0);
    send_word(OP_FIND, 32'sh7fff_ffff, 5'd1);
    send_word(OP_REMOVE_AT, 32'sd0, 5'd16);
    // fill to capacity
    for (int k = 0; k < 12; k++)
      send_word((k % 2 != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                (k == 6) ? 32'sd0 : $urandom, 5'd0);
    send_word(OP_PUSH_BACK, 32'sh5a5a_a5a5, 5'd0);
    send_word(OP_PUSH_FRONT, 32'sd1, 5'd0);
    send_word(OP_PUSH_BACK, 32'sd2, 5'd0);
    send_word(OP_FIND, 32'sh5a5a_a5a5, 5'd0);
    send_word(OP_FIND, -32'sd1, 5'd16);
    send_word(OP_REMOVE_AT, 32'sd0, 5'd15);
    send_word(OP_REMOVE_AT, 32'sd0, 5'd0);
    send_word(OP_REMOVE_AT, 32'sd0, 5'd16);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w = random_word((n / 40) % 2 == 0);
      send_word(w.op, w.value, w.position);
    end
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ordered_list_engine_unit_tb: PASS");
    end else begin
      $display("ordered_list_engine_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
